// ----- hw/rtl/gtc_pkg.sv -----
// Shared types, constants and tables for the GPS time to calendar converter.
// Used by every module of the block; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package gtc_pkg;

   localparam int WEEK_BITS = 13;
   localparam logic [12:0] WEEK_MASK = 13'((32'd1 << WEEK_BITS) - 1);

   localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
   localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
   localparam logic [15:0] MS_PER_MIN  = 16'd60000;

   // Reciprocals for floor division by the odd part of each divisor.
   localparam logic [7:0]  DAY_RECIP   = 8'd198;
   localparam logic [9:0]  HOUR_RECIP  = 10'd596;
   localparam logic [13:0] MIN_RECIP   = 14'd8947;
   localparam logic [21:0] YEAR_RECIP  = 22'd2939744;
   localparam logic [19:0] MONTH_RECIP = 20'd548273;

   // Julian day of the GPS epoch plus the 1537 day calendar shift.
   localparam logic [21:0] JDN_BASE    = 22'd2445782;
   localparam logic [23:0] YEAR_BIAS   = 24'd489;
   localparam logic [10:0] DAYS_PER_4Y = 11'd1461;
   localparam logic [13:0] MONTH_NUM   = 14'd10000;
   localparam logic [18:0] MONTH_DEN   = 19'd306001;
   localparam logic [12:0] YEAR_EPOCH  = 13'd4715;

   typedef struct packed {
      logic [12:0] gps_week;
      logic [29:0] week_millis;
   } req_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] milli_of_minute;
   } rsp_type;

   typedef struct packed {
      logic [21:0] jdn;
      logic [26:0] ms_day;
   } split_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] milli_of_minute;
   } clock_type;

   // Days from the month origin to the start of month index e: floor(30.6001 * e).
   function automatic logic [8:0] month_start(input logic [3:0] e);
      logic [8:0] days;
      case (e)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd30;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd91;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd183;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd244;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd336;
         4'd12:   days = 9'd367;
         4'd13:   days = 9'd397;
         4'd14:   days = 9'd428;
         default: days = 9'd459;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gtc_day_split.sv -----
// Front two pipeline stages: splits week milliseconds into whole days and
// milliseconds of day, and forms the shifted Julian day number. Uses gtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtc_day_split (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire gtc_pkg::req_type    in_item,
   output logic                     out_valid,
   output gtc_pkg::split_type       out_split
);

   logic [12:0] week_masked;
   logic [27:0] day_prod;
   logic        s1_valid_ff, s1_valid_in;
   logic [29:0] s1_millis_ff, s1_millis_in;
   logic [3:0]  s1_days_ff, s1_days_in;
   logic [21:0] s1_base_ff, s1_base_in;

   logic [30:0] day_sub;
   logic [27:0] day_rem;
   logic        day_carry;
   logic [3:0]  days;
   logic        s2_valid_ff, s2_valid_in;
   gtc_pkg::split_type s2_split_ff, s2_split_in;

   always_comb begin
      week_masked  = in_item.gps_week & gtc_pkg::WEEK_MASK;
      day_prod     = 28'(in_item.week_millis[29:10]) * 28'(gtc_pkg::DAY_RECIP);
      s1_valid_in  = in_valid;
      s1_millis_in = in_item.week_millis;
      s1_days_in   = day_prod[27:24];
      s1_base_in   = 22'(week_masked) * 22'd7 + gtc_pkg::JDN_BASE;
   end

   always_comb begin
      day_sub   = 31'(s1_millis_ff) - 31'(s1_days_ff) * 31'(gtc_pkg::MS_PER_DAY);
      day_rem   = day_sub[27:0];
      day_carry = (day_rem >= 28'(gtc_pkg::MS_PER_DAY));
      days      = s1_days_ff + 4'(day_carry);
      s2_valid_in        = s1_valid_ff;
      s2_split_in.jdn    = s1_base_ff + 22'(days);
      s2_split_in.ms_day = day_carry ? 27'(day_rem - 28'(gtc_pkg::MS_PER_DAY))
                                     : day_rem[26:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_millis_ff <= s1_millis_in;
      s1_days_ff   <= s1_days_in;
      s1_base_ff   <= s1_base_in;
      s2_split_ff  <= s2_split_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_split = s2_split_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/gtc_date.sv -----
// Six pipeline stages that turn the shifted Julian day number into year,
// month and day with exact integer arithmetic. Uses gtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtc_date (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [21:0]   in_jdn,
   output logic               out_valid,
   output gtc_pkg::date_type  out_date
);

   logic [23:0] y_val;
   logic [45:0] c_prod;
   logic        s3_valid_ff, s3_valid_in;
   logic [23:0] s3_y_ff, s3_y_in;
   logic [12:0] s3_c_ff, s3_c_in;
   logic [21:0] s3_jdn_ff, s3_jdn_in;

   logic [23:0] c_rem;
   logic        s4_valid_ff, s4_valid_in;
   logic [12:0] s4_c_ff, s4_c_in;
   logic [21:0] s4_jdn_ff, s4_jdn_in;

   logic [23:0] d_prod;
   logic [21:0] g_full;
   logic        s5_valid_ff, s5_valid_in;
   logic [8:0]  s5_g_ff, s5_g_in;
   logic [12:0] s5_c_ff, s5_c_in;

   logic [28:0] e_prod;
   logic        s6_valid_ff, s6_valid_in;
   logic [3:0]  s6_e_ff, s6_e_in;
   logic [8:0]  s6_g_ff, s6_g_in;
   logic [12:0] s6_c_ff, s6_c_in;

   logic [22:0] e_rem;
   logic        s7_valid_ff, s7_valid_in;
   logic [3:0]  s7_e_ff, s7_e_in;
   logic [8:0]  s7_g_ff, s7_g_in;
   logic [12:0] s7_c_ff, s7_c_in;

   logic [8:0]  dom;
   logic [3:0]  mon;
   logic [12:0] yr;
   logic        s8_valid_ff, s8_valid_in;
   gtc_pkg::date_type s8_date_ff, s8_date_in;

   always_comb begin
      y_val       = {in_jdn, 2'b00} - gtc_pkg::YEAR_BIAS;
      c_prod      = 46'(y_val) * 46'(gtc_pkg::YEAR_RECIP);
      s3_valid_in = in_valid;
      s3_y_in     = y_val;
      s3_c_in     = c_prod[44:32];
      s3_jdn_in   = in_jdn;
   end

   always_comb begin
      c_rem       = s3_y_ff - 24'(s3_c_ff) * 24'(gtc_pkg::DAYS_PER_4Y);
      s4_valid_in = s3_valid_ff;
      s4_c_in     = s3_c_ff + 13'(c_rem >= 24'(gtc_pkg::DAYS_PER_4Y));
      s4_jdn_in   = s3_jdn_ff;
   end

   always_comb begin
      d_prod      = 24'(s4_c_ff) * 24'(gtc_pkg::DAYS_PER_4Y);
      g_full      = s4_jdn_ff - d_prod[23:2];
      s5_valid_in = s4_valid_ff;
      s5_g_in     = g_full[8:0];
      s5_c_in     = s4_c_ff;
   end

   always_comb begin
      e_prod      = 29'(s5_g_ff) * 29'(gtc_pkg::MONTH_RECIP);
      s6_valid_in = s5_valid_ff;
      s6_e_in     = e_prod[27:24];
      s6_g_in     = s5_g_ff;
      s6_c_in     = s5_c_ff;
   end

   always_comb begin
      e_rem       = 23'(s6_g_ff) * 23'(gtc_pkg::MONTH_NUM)
                  - 23'(s6_e_ff) * 23'(gtc_pkg::MONTH_DEN);
      s7_valid_in = s6_valid_ff;
      s7_e_in     = s6_e_ff + 4'(e_rem >= 23'(gtc_pkg::MONTH_DEN));
      s7_g_in     = s6_g_ff;
      s7_c_in     = s6_c_ff;
   end

   always_comb begin
      dom = s7_g_ff - gtc_pkg::month_start(s7_e_ff);
      mon = (s7_e_ff >= 4'd14) ? (s7_e_ff - 4'd13) : (s7_e_ff - 4'd1);
      yr  = s7_c_ff - gtc_pkg::YEAR_EPOCH - 13'(mon >= 4'd3);
      s8_valid_in      = s7_valid_ff;
      s8_date_in.year  = yr[11:0];
      s8_date_in.month = mon;
      s8_date_in.day   = dom[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
         s6_valid_ff <= s6_valid_in;
         s7_valid_ff <= s7_valid_in;
         s8_valid_ff <= s8_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_y_ff    <= s3_y_in;
      s3_c_ff    <= s3_c_in;
      s3_jdn_ff  <= s3_jdn_in;
      s4_c_ff    <= s4_c_in;
      s4_jdn_ff  <= s4_jdn_in;
      s5_g_ff    <= s5_g_in;
      s5_c_ff    <= s5_c_in;
      s6_e_ff    <= s6_e_in;
      s6_g_ff    <= s6_g_in;
      s6_c_ff    <= s6_c_in;
      s7_e_ff    <= s7_e_in;
      s7_g_ff    <= s7_g_in;
      s7_c_ff    <= s7_c_in;
      s8_date_ff <= s8_date_in;
   end

   assign out_valid = s8_valid_ff;
   assign out_date  = s8_date_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/gtc_clock.sv -----
// Six pipeline stages that split milliseconds of day into hour, minute and
// milliseconds of minute, aligned with the date path. Uses gtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtc_clock (
   input  wire logic           clock,
   input  wire logic [26:0]    in_ms_day,
   output gtc_pkg::clock_type  out_time
);

   logic [29:0] h_prod;
   logic [26:0] s3_ms_ff, s3_ms_in;
   logic [4:0]  s3_hr_ff, s3_hr_in;

   logic [26:0] h_sub;
   logic        h_carry;
   logic [4:0]  s4_hr_ff, s4_hr_in;
   logic [21:0] s4_rem_ff, s4_rem_in;

   logic [30:0] m_prod;
   logic [4:0]  s5_hr_ff, s5_hr_in;
   logic [5:0]  s5_mn_ff, s5_mn_in;
   logic [21:0] s5_rem_ff, s5_rem_in;

   logic [21:0] m_sub;
   logic        m_carry;
   gtc_pkg::clock_type s6_time_ff, s6_time_in;
   gtc_pkg::clock_type s7_time_ff;
   gtc_pkg::clock_type s8_time_ff;

   always_comb begin
      h_prod   = 30'(in_ms_day[26:7]) * 30'(gtc_pkg::HOUR_RECIP);
      s3_ms_in = in_ms_day;
      s3_hr_in = h_prod[28:24];
   end

   always_comb begin
      h_sub     = s3_ms_ff - 27'(s3_hr_ff) * 27'(gtc_pkg::MS_PER_HOUR);
      h_carry   = (h_sub >= 27'(gtc_pkg::MS_PER_HOUR));
      s4_hr_in  = s3_hr_ff + 5'(h_carry);
      s4_rem_in = h_carry ? 22'(h_sub - 27'(gtc_pkg::MS_PER_HOUR)) : h_sub[21:0];
   end

   always_comb begin
      m_prod    = 31'(s4_rem_ff[21:5]) * 31'(gtc_pkg::MIN_RECIP);
      s5_hr_in  = s4_hr_ff;
      s5_mn_in  = m_prod[29:24];
      s5_rem_in = s4_rem_ff;
   end

   always_comb begin
      m_sub   = s5_rem_ff - 22'(s5_mn_ff) * 22'(gtc_pkg::MS_PER_MIN);
      m_carry = (m_sub >= 22'(gtc_pkg::MS_PER_MIN));
      s6_time_in.hour            = s5_hr_ff;
      s6_time_in.minute          = s5_mn_ff + 6'(m_carry);
      s6_time_in.milli_of_minute = m_carry ? 16'(m_sub - 22'(gtc_pkg::MS_PER_MIN))
                                           : m_sub[15:0];
   end

   always_ff @(posedge clock) begin
      s3_ms_ff   <= s3_ms_in;
      s3_hr_ff   <= s3_hr_in;
      s4_hr_ff   <= s4_hr_in;
      s4_rem_ff  <= s4_rem_in;
      s5_hr_ff   <= s5_hr_in;
      s5_mn_ff   <= s5_mn_in;
      s5_rem_ff  <= s5_rem_in;
      s6_time_ff <= s6_time_in;
      s7_time_ff <= s6_time_ff;
      s8_time_ff <= s7_time_ff;
   end

   assign out_time = s8_time_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/gps_time_to_calendar_top.sv -----
// Top level of the GPS time to calendar converter.
// Instantiates gtc_day_split, gtc_date and gtc_clock; uses gtc_pkg.
//
// A request transfer happens at a rising edge where start is high and busy is
// low. The request carries the GPS full week number and the milliseconds of
// the week. Busy is always low, so a new request may be presented every cycle.
// Each request produces exactly one response: rsp_valid is high for one cycle
// and rsp_item holds year, month, day, hour, minute and milliseconds of the
// minute for that cycle only. The receiver cannot hold off a response.
// Requests pass the day split stages and then the date stages; throughput is
// one conversion per cycle. The depth is set by the chain of reciprocal
// multiplies and their one-step remainder corrections in the date path, which
// the time-of-day path runs alongside. Responses keep request order.
// A synchronous reset clears every valid bit in the pipeline, so no response
// is issued for requests that were in flight; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module gps_time_to_calendar_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire gtc_pkg::req_type  req_item,
   output logic                   rsp_valid,
   output gtc_pkg::rsp_type       rsp_item
);

   logic               split_valid;
   gtc_pkg::split_type split;
   logic               date_valid;
   gtc_pkg::date_type  date;
   gtc_pkg::clock_type time_of_day;

   assign busy = 1'b0;

   gtc_day_split u_day_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_item   (req_item),
      .out_valid (split_valid),
      .out_split (split)
   );

   gtc_date u_date (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_jdn    (split.jdn),
      .out_valid (date_valid),
      .out_date  (date)
   );

   gtc_clock u_clock (
      .clock     (clock),
      .in_ms_day (split.ms_day),
      .out_time  (time_of_day)
   );

   always_comb begin
      rsp_valid                = date_valid;
      rsp_item.year            = date.year;
      rsp_item.month           = date.month;
      rsp_item.day             = date.day;
      rsp_item.hour            = time_of_day.hour;
      rsp_item.minute          = time_of_day.minute;
      rsp_item.milli_of_minute = time_of_day.milli_of_minute;
   end

endmodule

`default_nettype wire
